/* rtl/mrs_pkg.sv */
`timescale 1ns / 1ps
package mrs_pkg;

	localparam int CFG_COUNT = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int DRAFT_W = 5;
	localparam int CHUNK_W = 5;
	localparam int INDEX_W = 7;
	localparam int VALUE_W = 32;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam int STAT_POSITIONS = 0;
	localparam int STAT_HITS = 1;
	localparam int STAT_RUNS = 2;
	localparam int STAT_RUN_SUM = 3;
	localparam int STAT_ADVANCE_BASE = 4;

	localparam logic [DRAFT_W-1:0] DRAFT_RESET [CFG_COUNT] =
		'{5'd2, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16};

	typedef struct packed {
		logic valid;
		logic hit;
		logic eos;
	} push_t;

	// saturating add, counter of cw bits held in the low bits
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
		input int cw);
		logic [64:0] s;
		logic [64:0] m;
		s = {1'b0, a} + {1'b0, b};
		m = (65'd1 << cw) - 65'd1;
		return (s > m) ? m[63:0] : s[63:0];
	endfunction

endpackage

/* rtl/mrs_lane.sv */
`timescale 1ns / 1ps
module mrs_lane
	import mrs_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  push_t                  push,
	input  logic [DRAFT_W-1:0]     draft_len,
	output logic [COUNT_WIDTH-1:0] advance,
	output logic [COUNT_WIDTH-1:0] verify
);

	logic [CHUNK_W-1:0] matches_q;
	logic [CHUNK_W-1:0] matches_d;
	logic [COUNT_WIDTH-1:0] advance_q;
	logic [COUNT_WIDTH-1:0] verify_q;
	logic               gather;
	logic               close;
	logic [CHUNK_W:0]   amount;

	always_comb begin
		gather = push.hit && (matches_q < CHUNK_W'(draft_len));
		matches_d = gather ? matches_q + CHUNK_W'(1) : '0;
		// verifier position, or sequence end with an open chunk
		close = !gather || (push.eos && (matches_d != '0));
		amount = gather ? {1'b0, matches_d} + (CHUNK_W+1)'(1)
			: {1'b0, matches_q} + (CHUNK_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matches_q <= '0;
			advance_q <= '0;
			verify_q <= '0;
		end else if (push.valid) begin
			matches_q <= close ? '0 : matches_d;
			if (close) begin
				advance_q <= COUNT_WIDTH'(sat_add(64'(advance_q), 64'(amount), COUNT_WIDTH));
				verify_q <= COUNT_WIDTH'(sat_add(64'(verify_q), 64'd1, COUNT_WIDTH));
			end
		end
	end

	assign advance = advance_q;
	assign verify = verify_q;

endmodule

/* rtl/mrs_run.sv */
`timescale 1ns / 1ps
module mrs_run
	import mrs_pkg::*;
#(
	parameter int HIST_CAP = 63,
	parameter int MAX_SEQ_LEN = 4096,
	parameter int COUNT_WIDTH = 32,
	parameter int HW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  push_t                  push,
	output logic [COUNT_WIDTH-1:0] positions,
	output logic [COUNT_WIDTH-1:0] hits,
	output logic [COUNT_WIDTH-1:0] runs,
	output logic [COUNT_WIDTH-1:0] run_sum,
	output logic                   close,
	output logic [HW-1:0]          close_addr
);

	localparam int RW = $clog2(2 * MAX_SEQ_LEN);
	localparam logic [RW-1:0] RUN_LIMIT = RW'(2 * MAX_SEQ_LEN - 1);

	logic [RW-1:0] run_q;
	logic [RW-1:0] run_d;
	logic [COUNT_WIDTH-1:0] positions_q;
	logic [COUNT_WIDTH-1:0] hits_q;
	logic [COUNT_WIDTH-1:0] runs_q;
	logic [COUNT_WIDTH-1:0] run_sum_q;

	always_comb begin
		run_d = (push.hit && (run_q < RUN_LIMIT)) ? run_q + RW'(1) : run_q;
		close = (!push.hit || push.eos) && (run_d != '0);
		// longer runs share the top bin
		if (32'(run_d) >= HIST_CAP) close_addr = HW'(HIST_CAP - 1);
		else close_addr = HW'(32'(run_d) - 32'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			positions_q <= '0;
			hits_q <= '0;
			runs_q <= '0;
			run_sum_q <= '0;
		end else if (push.valid) begin
			positions_q <= COUNT_WIDTH'(sat_add(64'(positions_q), 64'd1, COUNT_WIDTH));
			if (push.hit) begin
				hits_q <= COUNT_WIDTH'(sat_add(64'(hits_q), 64'd1, COUNT_WIDTH));
			end
			if (close) begin
				runs_q <= COUNT_WIDTH'(sat_add(64'(runs_q), 64'd1, COUNT_WIDTH));
				run_sum_q <= COUNT_WIDTH'(sat_add(64'(run_sum_q), 64'(run_d), COUNT_WIDTH));
				run_q <= '0;
			end else begin
				run_q <= run_d;
			end
		end
	end

	assign positions = positions_q;
	assign hits = hits_q;
	assign runs = runs_q;
	assign run_sum = run_sum_q;

endmodule

/* rtl/mrs_hist.sv */
`timescale 1ns / 1ps
module mrs_hist
	import mrs_pkg::*;
#(
	parameter int HIST_CAP = 63,
	parameter int COUNT_WIDTH = 32,
	parameter int HW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [HW-1:0]          addr_s1,
	input  logic                   inc_s1,
	output logic [COUNT_WIDTH-1:0] value
);

	logic [COUNT_WIDTH-1:0] mem [HIST_CAP];
	logic [HIST_CAP-1:0]    valid_q;
	logic [HW-1:0]          addr_s2;
	logic                   inc_s2;
	logic [COUNT_WIDTH-1:0] rdata_s2;
	logic                   vld_s2;
	logic                   byp_s2;
	logic [COUNT_WIDTH-1:0] fwd_s2;
	logic [COUNT_WIDTH-1:0] next_s2;
	logic                   vld_s1;

	always_comb begin
		if (byp_s2) value = fwd_s2;
		else if (vld_s2) value = rdata_s2;
		else value = '0;
		next_s2 = COUNT_WIDTH'(sat_add(64'(value), 64'd1, COUNT_WIDTH));
		vld_s1 = (32'(addr_s1) < HIST_CAP) ? valid_q[addr_s1] : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			inc_s2 <= 1'b0;
			byp_s2 <= 1'b0;
		end else if (en) begin
			inc_s2 <= inc_s1;
			// bin being written this cycle forwards to the next lookup
			byp_s2 <= inc_s2 && (addr_s2 == addr_s1);
			if (inc_s2) begin
				valid_q[addr_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s2 <= addr_s1;
			vld_s2 <= vld_s1;
			fwd_s2 <= next_s2;
			if (32'(addr_s1) < HIST_CAP) begin
				rdata_s2 <= mem[addr_s1];
			end
			if (inc_s2) begin
				mem[addr_s2] <= next_s2;
			end
		end
	end

endmodule

/* rtl/match_run_statistics.sv */
`timescale 1ns / 1ps
// a read request passes the s1 and s2 registers and then the output register before its result is valid
// throughput: one request per cycle, pushes and reads alike; the pipeline
// stalls only while a result waits in the output register
// histogram bins are one memory with a read and a write per cycle
// reset clears all counters and histogram bin valid bits, draft lengths load 2,4,6,8,12,16
module match_run_statistics
	import mrs_pkg::*;
#(
	parameter int NUM_DRAFT_LENGTHS = 6,
	parameter int HIST_CAP = 63,
	parameter int MAX_SEQ_LEN = 4096,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // match_bit, stat_index
	input  logic                   s_axis_tuser,  // operation
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // stat_value, echoed_index, zero pad
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DRAFT_W-1:0]     cfg_data
);

	localparam int N = NUM_DRAFT_LENGTHS;
	localparam int HW = (HIST_CAP > 1) ? $clog2(HIST_CAP) : 1;
	localparam int VERIFY_BASE = STAT_ADVANCE_BASE + N;
	localparam int HIST_BASE = STAT_ADVANCE_BASE + 2 * N;

	logic [DRAFT_W-1:0] draft_len_q [CFG_COUNT];
	logic               en;

	logic               valid_s1;
	logic               op_s1;
	logic               hit_s1;
	logic               eos_s1;
	logic [INDEX_W-1:0] idx_s1;

	logic               read_s2;
	logic               hist_sel_s2;
	logic [INDEX_W-1:0] idx_s2;
	logic [VALUE_W-1:0] value_s2;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [INDEX_W-1:0] out_index_q;

	push_t push;
	logic [COUNT_WIDTH-1:0] positions;
	logic [COUNT_WIDTH-1:0] hits;
	logic [COUNT_WIDTH-1:0] runs;
	logic [COUNT_WIDTH-1:0] run_sum;
	logic [COUNT_WIDTH-1:0] advance [N];
	logic [COUNT_WIDTH-1:0] verify [N];
	logic                   close;
	logic [HW-1:0]          close_addr;
	logic [HW-1:0]          hist_addr;
	logic [COUNT_WIDTH-1:0] hist_value;
	logic [COUNT_WIDTH-1:0] sel_value;
	logic                   hist_sel;
	logic [VALUE_W-1:0]     result;

	assign en = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CFG_COUNT; k++) begin
				draft_len_q[k] <= DRAFT_RESET[k];
			end
		end else if (cfg_we) begin
			for (int k = 0; k < CFG_COUNT; k++) begin
				if (32'(cfg_index) == k) draft_len_q[k] <= cfg_data;
			end
		end
	end

	assign push = '{valid: en && valid_s1 && (op_s1 == OP_PUSH), hit: hit_s1, eos: eos_s1};

	mrs_run #(
		.HIST_CAP(HIST_CAP),
		.MAX_SEQ_LEN(MAX_SEQ_LEN),
		.COUNT_WIDTH(COUNT_WIDTH),
		.HW(HW)
	) u_run (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.positions(positions),
		.hits(hits),
		.runs(runs),
		.run_sum(run_sum),
		.close(close),
		.close_addr(close_addr)
	);

	for (genvar k = 0; k < N; k++) begin : g_lane
		localparam int R = (k < CFG_COUNT) ? k : CFG_COUNT - 1;
		mrs_lane #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.push(push),
			.draft_len(draft_len_q[R]),
			.advance(advance[k]),
			.verify(verify[k])
		);
	end

	// statistic select for reads, histogram address for reads and pushes
	always_comb begin
		sel_value = '0;
		if (32'(idx_s1) == STAT_POSITIONS) sel_value = positions;
		if (32'(idx_s1) == STAT_HITS) sel_value = hits;
		if (32'(idx_s1) == STAT_RUNS) sel_value = runs;
		if (32'(idx_s1) == STAT_RUN_SUM) sel_value = run_sum;
		for (int k = 0; k < N; k++) begin
			if (32'(idx_s1) == STAT_ADVANCE_BASE + k) sel_value = advance[k];
			if (32'(idx_s1) == VERIFY_BASE + k) sel_value = verify[k];
		end
		hist_sel = (32'(idx_s1) >= HIST_BASE) && (32'(idx_s1) < HIST_BASE + HIST_CAP);
		if (op_s1 == OP_READ) begin
			hist_addr = hist_sel ? HW'(32'(idx_s1) - HIST_BASE) : '0;
		end else begin
			hist_addr = close_addr;
		end
	end

	mrs_hist #(
		.HIST_CAP(HIST_CAP),
		.COUNT_WIDTH(COUNT_WIDTH),
		.HW(HW)
	) u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.addr_s1(hist_addr),
		.inc_s1(valid_s1 && (op_s1 == OP_PUSH) && close),
		.value(hist_value)
	);

	assign result = hist_sel_s2 ? VALUE_W'(64'(hist_value)) : value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			read_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
			read_s2 <= valid_s1 && (op_s1 == OP_READ);
			out_valid_q <= read_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_axis_tuser;
			hit_s1 <= s_axis_tdata[0];
			eos_s1 <= s_axis_tlast;
			idx_s1 <= s_axis_tdata[INDEX_W:1];
			hist_sel_s2 <= hist_sel;
			idx_s2 <= idx_s1;
			value_s2 <= VALUE_W'(64'(sel_value));
			out_value_q <= result;
			out_index_q <= idx_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {(OUT_DATA_W - VALUE_W - INDEX_W)'(0), out_index_q, out_value_q};

endmodule

/* tb/sv/match_run_statistics_test.sv */
`timescale 1ns / 1ps
module match_run_statistics_test;
	import mrs_pkg::*;

	localparam int NUM_DRAFTS = CFG_COUNT;
	localparam int HIST_BINS = 63;
	localparam int STAT_VERIFY_BASE = STAT_ADVANCE_BASE + NUM_DRAFTS;
	localparam int STAT_HIST_BASE = STAT_VERIFY_BASE + NUM_DRAFTS;
	localparam int STAT_LAST = STAT_HIST_BASE + HIST_BINS - 1;
	localparam int RUN_CAP = 2 * 4096 - 1;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] index;
	} stat_reply_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;  // match_bit, stat_index
	logic s_axis_tuser;                  // operation
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata; // stat_value, echoed_index, zero pad
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DRAFT_W-1:0] cfg_data;

	// predicted block state
	logic [DRAFT_W-1:0] draft_len [NUM_DRAFTS];
	logic [VALUE_W-1:0] position_total;
	logic [VALUE_W-1:0] hit_total;
	logic [VALUE_W-1:0] run_total;
	logic [VALUE_W-1:0] run_len_total;
	logic [12:0] open_run;
	logic [VALUE_W-1:0] run_bins [HIST_BINS];
	logic [CHUNK_W-1:0] chunk_hits [NUM_DRAFTS];
	logic [VALUE_W-1:0] advance_total [NUM_DRAFTS];
	logic [VALUE_W-1:0] verify_total [NUM_DRAFTS];

	stat_reply_t pending_replies [$];

	int error_count = 0;
	int push_count = 0;
	int read_count = 0;
	int setting_count = 0;
	int longest_run = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	match_run_statistics u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic [VALUE_W-1:0] sat_inc(input logic [VALUE_W-1:0] a,
		input logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VALUE_W] ? '1 : s[VALUE_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] lookup_stat(input int idx);
		if (idx == STAT_POSITIONS) return position_total;
		if (idx == STAT_HITS) return hit_total;
		if (idx == STAT_RUNS) return run_total;
		if (idx == STAT_RUN_SUM) return run_len_total;
		if (idx < STAT_VERIFY_BASE) return advance_total[idx - STAT_ADVANCE_BASE];
		if (idx < STAT_HIST_BASE) return verify_total[idx - STAT_VERIFY_BASE];
		if (idx <= STAT_LAST) return run_bins[idx - STAT_HIST_BASE];
		return '0;
	endfunction

	task automatic reset_prediction();
		for (int k = 0; k < NUM_DRAFTS; k++) begin
			draft_len[k] = DRAFT_RESET[k];
			chunk_hits[k] = '0;
			advance_total[k] = '0;
			verify_total[k] = '0;
		end
		for (int b = 0; b < HIST_BINS; b++)
			run_bins[b] = '0;
		position_total = '0;
		hit_total = '0;
		run_total = '0;
		run_len_total = '0;
		open_run = '0;
	endtask

	task automatic close_chunk(input int k);
		advance_total[k] = sat_inc(advance_total[k], VALUE_W'(chunk_hits[k]) + 1);
		verify_total[k] = sat_inc(verify_total[k], 1);
		chunk_hits[k] = '0;
	endtask

	task automatic predict_push(input logic hit, input logic eos);
		int bin;
		position_total = sat_inc(position_total, 1);
		if (hit) begin
			hit_total = sat_inc(hit_total, 1);
			if (open_run < RUN_CAP)
				open_run = open_run + 13'd1;
		end
		if ((!hit || eos) && open_run != 0) begin
			if (int'(open_run) > longest_run)
				longest_run = int'(open_run);
			bin = (int'(open_run) < HIST_BINS) ? int'(open_run) : HIST_BINS;
			run_total = sat_inc(run_total, 1);
			run_len_total = sat_inc(run_len_total, VALUE_W'(open_run));
			run_bins[bin-1] = sat_inc(run_bins[bin-1], 1);
			open_run = '0;
		end
		for (int k = 0; k < NUM_DRAFTS; k++) begin
			if (hit && chunk_hits[k] < draft_len[k])
				chunk_hits[k] = chunk_hits[k] + CHUNK_W'(1);
			else
				close_chunk(k);
			if (eos && chunk_hits[k] != 0)
				close_chunk(k);
		end
	endtask

	task automatic send_request(input logic op, input logic hit, input logic eos,
		input logic [INDEX_W-1:0] idx);
		stat_reply_t reply;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= eos;
		s_axis_tdata <= {idx, hit};
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_READ) begin
			reply.value = lookup_stat(idx);
			reply.index = idx;
			pending_replies.push_back(reply);
			read_count++;
		end else begin
			predict_push(hit, eos);
			push_count++;
		end
	endtask

	task automatic push_bit(input logic hit, input logic eos);
		send_request(OP_PUSH, hit, eos, INDEX_W'($urandom));
	endtask

	task automatic read_stat(input int idx);
		send_request(OP_READ, 1'($urandom), 1'($urandom), INDEX_W'(idx));
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_drafts(input int v0, input int v1, input int v2, input int v3,
		input int v4, input int v5);
		int vals [NUM_DRAFTS];
		vals = '{v0, v1, v2, v3, v4, v5};
		settle();
		for (int k = 0; k < NUM_DRAFTS; k++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_INDEX_W'(k);
			cfg_data <= DRAFT_W'(vals[k]);
			draft_len[k] = DRAFT_W'(vals[k]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		setting_count++;
	endtask

	function automatic int pick_index();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(STAT_LAST + 1, 127);
		return $urandom_range(0, STAT_LAST);
	endfunction

	task automatic test_reset_values();
		read_stat(STAT_POSITIONS);
		read_stat(STAT_RUN_SUM);
		read_stat(STAT_ADVANCE_BASE);
		read_stat(STAT_VERIFY_BASE);
		read_stat(STAT_HIST_BASE);
		read_stat(STAT_LAST);
		read_stat(STAT_LAST + 1);
		read_stat(127);
	endtask

	task automatic test_run_edges();
		// run closed by a miss, then by end of sequence, then empty sequence
		push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		push_bit(1'b1, 1'b1);
		push_bit(1'b0, 1'b1);
		read_stat(STAT_RUNS);
		read_stat(STAT_RUN_SUM);
		read_stat(STAT_HIST_BASE);
		read_stat(STAT_HIST_BASE + 1);
		read_stat(STAT_ADVANCE_BASE);
	endtask

	task automatic test_draft_extremes();
		write_drafts(1, 16, 0, 16, 1, 5);
		push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b0);
		push_bit(1'b1, 1'b0);
		// shrink draft lengths under an open chunk
		write_drafts(1, 1, 0, 1, 16, 2);
		push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b1);
		for (int k = 0; k < NUM_DRAFTS; k += 2) begin
			read_stat(STAT_ADVANCE_BASE + k);
			read_stat(STAT_VERIFY_BASE + k + 1);
		end
	endtask

	task automatic test_long_run();
		// run well past the top bin length, lands in the top bin
		for (int i = 0; i < HIST_BINS + 40; i++)
			push_bit(1'b1, 1'b0);
		push_bit(1'b0, 1'b0);
		read_stat(STAT_RUN_SUM);
		read_stat(STAT_LAST);
		read_stat(STAT_HITS);
	endtask

	task automatic test_random_traffic(input int items);
		int start;
		int len;
		int hit_pct;
		int next_pause;
		start = push_count + read_count;
		next_pause = start + $urandom_range(100, 300);
		while (push_count + read_count - start < items) begin
			if ($urandom_range(0, 99) < 85) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
				case ($urandom_range(0, 3))
					0: hit_pct = 20;
					1: hit_pct = 50;
					2: hit_pct = 80;
					default: hit_pct = 95;
				endcase
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 20)
						read_stat(pick_index());
					push_bit(1'($urandom_range(0, 99) < hit_pct), 1'(i == len - 1));
				end
			end else if ($urandom_range(0, 1) == 0) begin
				push_bit(1'($urandom), 1'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) read_stat(pick_index());
			end
			if (push_count + read_count >= next_pause) begin
				wait_results_done();
				next_pause = push_count + read_count + $urandom_range(100, 300);
			end
		end
		for (int k = 0; k < NUM_DRAFTS; k++) begin
			read_stat(STAT_ADVANCE_BASE + k);
			read_stat(STAT_VERIFY_BASE + k);
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		stat_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result value %h index %0d", $time,
					m_axis_tdata[VALUE_W-1:0], m_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_axis_tdata[VALUE_W-1:0] !== want.value) begin
					$display("%0t: stat %0d value expected %h got %h", $time, want.index,
						want.value, m_axis_tdata[VALUE_W-1:0]);
					error_count++;
				end
				if (m_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W] !== want.index) begin
					$display("%0t: echoed index expected %0d got %0d", $time, want.index,
						m_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_PUSH;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_prediction();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_run_edges();
		test_draft_extremes();
		test_long_run();

		write_drafts(16, 16, 16, 16, 16, 16);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(370);

		write_drafts(1, 1, 1, 1, 1, 1);
		send_idle_pct = 66;
		recv_stall_pct = 0;
		test_random_traffic(370);

		write_drafts($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
			$urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16));
		send_idle_pct = 0;
		recv_stall_pct = 66;
		test_random_traffic(370);

		write_drafts(2, 4, 6, 8, 12, 16);
		send_idle_pct = 13;
		recv_stall_pct = 13;
		test_random_traffic(370);

		settle();
		$display("covered %0d pushes and %0d reads over %0d draft length settings", push_count,
			read_count, setting_count);
		$display("longest run seen %0d, mismatches %0d", longest_run, error_count);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/mrs_pkg.sv
rtl/mrs_lane.sv
rtl/mrs_run.sv
rtl/mrs_hist.sv
rtl/match_run_statistics.sv
tb/sv/match_run_statistics_test.sv
